@@ sv/nabd_pkg.sv @@
// ----------------------------------------------------------------------------
// nabd_pkg
// Shared widths, register codes and divider request/response types of the
// bin-averaging downsampler.
// ----------------------------------------------------------------------------
package nabd_pkg;

	localparam int SAMPLE_W = 32;
	localparam int DIM_W    = 12;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 2;
	localparam int ACC_W    = 44;
	localparam int MAX_DIM  = 4096;
	localparam int RAM_W    = ACC_W + CFG_W;
	localparam int DIV_IT_W = 6;

	localparam logic [IDX_W-1:0] CFG_IN_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_IN_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [CFG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
		logic [CFG_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ sv/nabd_sample_if.sv @@
// ----------------------------------------------------------------------------
// nabd_sample_if
// Input sample channel: valid/ready with one matrix element per beat.
// ----------------------------------------------------------------------------
interface nabd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [nabd_pkg::SAMPLE_W-1:0] sample_value;
	logic                          sample_finite;
	logic                          frame_start;

	modport source (output valid, sample_value, sample_finite, frame_start, input ready);
	modport sink   (input valid, sample_value, sample_finite, frame_start, output ready);
endinterface

@@ sv/nabd_result_if.sv @@
// ----------------------------------------------------------------------------
// nabd_result_if
// Result channel: valid/ready with one binned mean per beat.
// ----------------------------------------------------------------------------
interface nabd_result_if;
	logic                          valid;
	logic                          ready;
	logic [nabd_pkg::SAMPLE_W-1:0] mean_value;
	logic                          mean_valid;
	logic [nabd_pkg::DIM_W-1:0]    out_column;
	logic [nabd_pkg::DIM_W-1:0]    out_row;
	logic                          last_of_frame;
	logic                          config_error;

	modport source (output valid, mean_value, mean_valid, out_column, out_row,
		last_of_frame, config_error, input ready);
	modport sink   (input valid, mean_value, mean_valid, out_column, out_row,
		last_of_frame, config_error, output ready);
endinterface

@@ sv/nabd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// nabd_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface nabd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [nabd_pkg::IDX_W-1:0] index;
	logic [nabd_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/nabd_ram.sv @@
// ----------------------------------------------------------------------------
// nabd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nabd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/nabd_div.sv @@
// ----------------------------------------------------------------------------
// nabd_div
// Unsigned restoring divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module nabd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  nabd_pkg::div_req_t req,
	output nabd_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [nabd_pkg::DIV_IT_W-1:0]   iter_q;
	logic [nabd_pkg::ACC_W-1:0]      num_q;
	logic [nabd_pkg::CFG_W-1:0]      rem_q;
	logic [nabd_pkg::CFG_W-1:0]      den_q;
	logic [nabd_pkg::CFG_W:0]        trial;
	logic                            fits;

	assign trial = {rem_q, num_q[nabd_pkg::ACC_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == nabd_pkg::DIV_IT_W'(nabd_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[nabd_pkg::ACC_W-2:0], fits};
			rem_q <= fits ? nabd_pkg::CFG_W'(trial - {1'b0, den_q})
			              : trial[nabd_pkg::CFG_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = num_q;
	assign rsp.remainder = rem_q;

endmodule

@@ sv/nan_aware_matrix_bin_downsample.sv @@
// ----------------------------------------------------------------------------
// nan_aware_matrix_bin_downsample
// Result path: the beat that closes an output bin passes two serial divides
//   and the store RMW (ST_DIV_ROW, ST_UPD, ST_DIV_COL) to ST_FIN, which waits
//   for the output register; a config error beat goes straight to ST_FIN.
// Throughput: one sample per cycle inside a row bin; ready is low outside
//   ST_IDLE, so it drops when a row bin closes, when an output bin closes, on
//   a config error, and after a config write while the bin counters are rebuilt.
// Reset: config registers go to 1, positions and the row accumulator to zero;
//   the column store is not cleared and holds data only once written.
// ----------------------------------------------------------------------------
module nan_aware_matrix_bin_downsample (
	input  logic                 clk,
	input  logic                 arst_n,
	nabd_cfg_if.sink             cfg,
	nabd_sample_if.sink          sample,
	nabd_result_if.source        result
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RC_X    = 7'b0000010,
		ST_RC_Y    = 7'b0000100,
		ST_DIV_ROW = 7'b0001000,
		ST_UPD     = 7'b0010000,
		ST_DIV_COL = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	localparam int SW = nabd_pkg::SAMPLE_W;
	localparam int DW = nabd_pkg::DIM_W;
	localparam int CW = nabd_pkg::CFG_W;
	localparam int AW = nabd_pkg::ACC_W;

	state_t state_q;
	logic   dirty_q;
	logic   start_q;

	logic [CW-1:0] iw_q, ih_q, ow_q, oh_q;

	logic [DW-1:0] x_q, y_q, cb_q, rb_q;
	logic [CW-1:0] r_q, rr_q;
	logic [AW-1:0] rsum_q;
	logic [CW-1:0] rcnt_q;

	logic [AW-1:0] bsum_q;
	logic [CW-1:0] bcnt_q;
	logic [DW-1:0] cb_s1, rb_s1;
	logic          first_s1, rclose_s1, last_s1;
	logic [AW-1:0] csum_q;
	logic [CW-1:0] ccnt_q;

	logic [SW-1:0] res_value_q;
	logic          res_mvalid_q, res_last_q, res_err_q;
	logic [DW-1:0] res_col_q, res_row_q;

	logic          out_v_q;
	logic [SW-1:0] out_value_q;
	logic          out_mvalid_q, out_last_q, out_err_q;
	logic [DW-1:0] out_col_q, out_row_q;

	nabd_pkg::div_req_t div_req;
	nabd_pkg::div_rsp_t div_rsp;

	logic                         ram_we, ram_re;
	logic [nabd_pkg::RAM_W-1:0]   ram_wdata, ram_rdata;

	// accept-side arithmetic
	logic          cfg_bad, restart, in_acc;
	logic [DW-1:0] ex, ey, ecb, erb;
	logic [CW-1:0] er, err;
	logic [AW-1:0] esum, nsum;
	logic [CW-1:0] ecnt, ncnt;
	logic [CW:0]   r_nxt, rr_nxt;
	logic          cstep, rstep, xwrap, ywrap, col_close;
	logic [24:0]   prod_x, prod_y;

	// update-side arithmetic
	logic [AW-1:0] row_mean, base_sum, new_sum, col_mean;
	logic [CW-1:0] base_cnt, new_cnt;

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == ST_IDLE) && !dirty_q;
	assign in_acc       = sample.valid && sample.ready;

	assign cfg_bad = (iw_q == '0) || (ih_q == '0) || (ow_q == '0) || (oh_q == '0) ||
		(iw_q > CW'(nabd_pkg::MAX_DIM)) || (ih_q > CW'(nabd_pkg::MAX_DIM)) ||
		(ow_q > iw_q) || (oh_q > ih_q);

	assign restart = sample.frame_start || ({1'b0, x_q} >= iw_q) || ({1'b0, y_q} >= ih_q);

	assign ex   = restart ? '0 : x_q;
	assign ey   = restart ? '0 : y_q;
	assign ecb  = restart ? '0 : cb_q;
	assign erb  = restart ? '0 : rb_q;
	assign er   = restart ? '0 : r_q;
	assign err  = restart ? '0 : rr_q;
	assign esum = restart ? '0 : rsum_q;
	assign ecnt = restart ? '0 : rcnt_q;

	assign nsum = esum + (sample.sample_finite ?
		{{(AW-SW){sample.sample_value[SW-1]}}, sample.sample_value} : AW'(0));
	assign ncnt = ecnt + CW'(sample.sample_finite);

	assign r_nxt     = {1'b0, er} + {1'b0, ow_q};
	assign rr_nxt    = {1'b0, err} + {1'b0, oh_q};
	assign cstep     = r_nxt >= {1'b0, iw_q};
	assign rstep     = rr_nxt >= {1'b0, ih_q};
	assign xwrap     = ({1'b0, ex} + 1'b1) == iw_q;
	assign ywrap     = ({1'b0, ey} + 1'b1) == ih_q;
	assign col_close = xwrap || cstep;

	assign prod_x = 25'(x_q) * 25'(ow_q);
	assign prod_y = 25'(y_q) * 25'(oh_q);

	always_comb begin
		div_req.start    = start_q;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (1'b1)
			state_q[1]: begin
				div_req.dividend = AW'(prod_x);
				div_req.divisor  = iw_q;
			end
			state_q[2]: begin
				div_req.dividend = AW'(prod_y);
				div_req.divisor  = ih_q;
			end
			state_q[3]: begin
				div_req.dividend = bsum_q[AW-1] ? -bsum_q : bsum_q;
				div_req.divisor  = bcnt_q;
			end
			state_q[5]: begin
				div_req.dividend = csum_q[AW-1] ? -csum_q : csum_q;
				div_req.divisor  = ccnt_q;
			end
			default: begin
				div_req.dividend = '0;
				div_req.divisor  = '0;
			end
		endcase
	end

	assign row_mean = bsum_q[AW-1] ? -div_rsp.quotient : div_rsp.quotient;
	assign col_mean = csum_q[AW-1] ? -div_rsp.quotient : div_rsp.quotient;
	assign base_sum = first_s1 ? '0 : ram_rdata[nabd_pkg::RAM_W-1:CW];
	assign base_cnt = first_s1 ? '0 : ram_rdata[CW-1:0];
	assign new_sum  = base_sum + ((bcnt_q != '0) ? row_mean : AW'(0));
	assign new_cnt  = base_cnt + CW'(bcnt_q != '0);

	assign ram_re    = (state_q == ST_DIV_ROW) && start_q;
	assign ram_we    = (state_q == ST_UPD);
	assign ram_wdata = {new_sum, new_cnt};

	nabd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	nabd_ram #(
		.WIDTH (nabd_pkg::RAM_W),
		.DEPTH (nabd_pkg::MAX_DIM)
	) u_col_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cb_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cb_s1),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b0;
			start_q <= 1'b0;
			iw_q    <= CW'(1);
			ih_q    <= CW'(1);
			ow_q    <= CW'(1);
			oh_q    <= CW'(1);
			x_q     <= '0;
			y_q     <= '0;
			cb_q    <= '0;
			rb_q    <= '0;
			r_q     <= '0;
			rr_q    <= '0;
			rsum_q  <= '0;
			rcnt_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg.valid) begin
				dirty_q <= 1'b1;
				unique case (cfg.index)
					nabd_pkg::CFG_IN_WIDTH:   iw_q <= cfg.data;
					nabd_pkg::CFG_IN_HEIGHT:  ih_q <= cfg.data;
					nabd_pkg::CFG_OUT_WIDTH:  ow_q <= cfg.data;
					nabd_pkg::CFG_OUT_HEIGHT: oh_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (dirty_q) begin
						// bin counters follow x*out/in; rebuild them for new sizes
						if (!cfg.valid) begin
							dirty_q <= 1'b0;
						end
						state_q <= ST_RC_X;
						start_q <= 1'b1;
					end else if (in_acc && cfg_bad) begin
						state_q <= ST_FIN;
					end else if (in_acc) begin
						if (xwrap) begin
							x_q  <= '0;
							cb_q <= '0;
							r_q  <= '0;
							if (ywrap) begin
								y_q  <= '0;
								rb_q <= '0;
								rr_q <= '0;
							end else begin
								y_q  <= ey + 1'b1;
								rb_q <= erb + DW'(rstep);
								rr_q <= rstep ? CW'(rr_nxt - {1'b0, ih_q}) : CW'(rr_nxt);
							end
						end else begin
							x_q  <= ex + 1'b1;
							y_q  <= ey;
							cb_q <= ecb + DW'(cstep);
							rb_q <= erb;
							r_q  <= cstep ? CW'(r_nxt - {1'b0, iw_q}) : CW'(r_nxt);
							rr_q <= err;
						end
						if (col_close) begin
							rsum_q  <= '0;
							rcnt_q  <= '0;
							state_q <= ST_DIV_ROW;
							start_q <= 1'b1;
						end else begin
							rsum_q <= nsum;
							rcnt_q <= ncnt;
						end
					end
				end
				ST_RC_X: begin
					if (div_rsp.done) begin
						cb_q    <= div_rsp.quotient[DW-1:0];
						r_q     <= div_rsp.remainder;
						state_q <= ST_RC_Y;
						start_q <= 1'b1;
					end
				end
				ST_RC_Y: begin
					if (div_rsp.done) begin
						rb_q    <= div_rsp.quotient[DW-1:0];
						rr_q    <= div_rsp.remainder;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_ROW: begin
					if (div_rsp.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (rclose_s1) begin
						state_q <= ST_DIV_COL;
						start_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_COL: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_v_q || result.ready) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cfg_bad) begin
			res_value_q  <= '0;
			res_mvalid_q <= 1'b0;
			res_col_q    <= '0;
			res_row_q    <= '0;
			res_last_q   <= 1'b0;
			res_err_q    <= 1'b1;
		end else if (in_acc && col_close) begin
			bsum_q    <= nsum;
			bcnt_q    <= ncnt;
			cb_s1     <= ecb;
			rb_s1     <= erb;
			first_s1  <= err < oh_q;
			rclose_s1 <= ywrap || rstep;
			last_s1   <= xwrap && ywrap;
		end
		if (state_q == ST_UPD) begin
			csum_q <= new_sum;
			ccnt_q <= new_cnt;
		end
		if ((state_q == ST_DIV_COL) && div_rsp.done) begin
			res_value_q  <= (ccnt_q != '0) ? col_mean[SW-1:0] : SW'(0);
			res_mvalid_q <= ccnt_q != '0;
			res_col_q    <= cb_s1;
			res_row_q    <= rb_s1;
			res_last_q   <= last_s1;
			res_err_q    <= 1'b0;
		end
		if ((state_q == ST_FIN) && (!out_v_q || result.ready)) begin
			out_value_q  <= res_value_q;
			out_mvalid_q <= res_mvalid_q;
			out_col_q    <= res_col_q;
			out_row_q    <= res_row_q;
			out_last_q   <= res_last_q;
			out_err_q    <= res_err_q;
		end
	end

	assign result.valid         = out_v_q;
	assign result.mean_value    = out_value_q;
	assign result.mean_valid    = out_mvalid_q;
	assign result.out_column    = out_col_q;
	assign result.out_row       = out_row_q;
	assign result.last_of_frame = out_last_q;
	assign result.config_error  = out_err_q;

endmodule

@@ tb/nan_aware_matrix_bin_downsample_tb.sv @@
// ----------------------------------------------------------------------------
// nan_aware_matrix_bin_downsample_tb
// Streams matrices through the bin-averaging downsampler over several size
// settings and compares every result beat with an in-bench predictor.
// ----------------------------------------------------------------------------
module nan_aware_matrix_bin_downsample_tb;

	typedef struct packed {
		logic [nabd_pkg::SAMPLE_W-1:0] mean_value;
		logic                          mean_valid;
		logic [nabd_pkg::DIM_W-1:0]    out_column;
		logic [nabd_pkg::DIM_W-1:0]    out_row;
		logic                          last_of_frame;
		logic                          config_error;
	} bin_result_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	nabd_cfg_if    cfg_ch ();
	nabd_sample_if sample_ch ();
	nabd_result_if result_ch ();

	nan_aware_matrix_bin_downsample dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	// predictor state
	logic [nabd_pkg::CFG_W-1:0]  p_in_w, p_in_h, p_out_w, p_out_h;
	logic [nabd_pkg::ACC_W-1:0]  p_row_sum;
	logic [nabd_pkg::CFG_W-1:0]  p_row_cnt;
	longint unsigned             p_col_pos, p_row_pos;
	logic [nabd_pkg::ACC_W-1:0]  p_col_sum [nabd_pkg::MAX_DIM];
	logic [nabd_pkg::CFG_W-1:0]  p_col_cnt [nabd_pkg::MAX_DIM];

	bin_result_t expected_means [$];
	int          errors;
	int          idle_cycles;
	int          src_idle_pct;
	int          snk_idle_pct;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [nabd_pkg::ACC_W-1:0] trunc_mean(
		logic [nabd_pkg::ACC_W-1:0] sum, logic [nabd_pkg::CFG_W-1:0] cnt);
		longint s;
		longint q;
		s = longint'($signed(sum));
		q = s / longint'(cnt);
		return q[nabd_pkg::ACC_W-1:0];
	endfunction

	task automatic predict_bin(logic [nabd_pkg::SAMPLE_W-1:0] value, logic finite,
		logic fstart);
		bin_result_t r;
		longint unsigned x, y, cb, rb, iw, ih, ow, oh;
		bit col_close, row_close, row_first, last;
		logic [nabd_pkg::ACC_W-1:0] m;
		r = '0;
		iw = p_in_w; ih = p_in_h; ow = p_out_w; oh = p_out_h;
		if (iw == 0 || ih == 0 || ow == 0 || oh == 0 || iw > nabd_pkg::MAX_DIM ||
			ih > nabd_pkg::MAX_DIM || ow > iw || oh > ih) begin
			r.config_error = 1'b1;
			expected_means.push_back(r);
			return;
		end
		if (fstart || p_col_pos >= iw || p_row_pos >= ih) begin
			p_col_pos = 0;
			p_row_pos = 0;
			p_row_sum = '0;
			p_row_cnt = '0;
		end
		x = p_col_pos;
		y = p_row_pos;
		cb = (x * ow) / iw;
		rb = (y * oh) / ih;
		if (finite) begin
			p_row_sum = p_row_sum +
				{{(nabd_pkg::ACC_W-nabd_pkg::SAMPLE_W){value[nabd_pkg::SAMPLE_W-1]}}, value};
			p_row_cnt = p_row_cnt + 1'b1;
		end
		col_close = (x + 1 == iw) || (((x + 1) * ow) / iw != cb);
		row_close = (y + 1 == ih) || (((y + 1) * oh) / ih != rb);
		row_first = (y == 0) || (((y - 1) * oh) / ih != rb);
		last = (x + 1 == iw) && (y + 1 == ih);
		x++;
		if (x == iw) begin
			x = 0;
			y++;
			if (y == ih)
				y = 0;
		end
		p_col_pos = x;
		p_row_pos = y;
		if (!col_close)
			return;
		if (row_first) begin
			p_col_sum[cb] = '0;
			p_col_cnt[cb] = '0;
		end
		if (p_row_cnt != 0) begin
			p_col_sum[cb] = p_col_sum[cb] + trunc_mean(p_row_sum, p_row_cnt);
			p_col_cnt[cb] = p_col_cnt[cb] + 1'b1;
		end
		p_row_sum = '0;
		p_row_cnt = '0;
		if (!row_close)
			return;
		if (p_col_cnt[cb] != 0) begin
			m = trunc_mean(p_col_sum[cb], p_col_cnt[cb]);
			r.mean_value = m[nabd_pkg::SAMPLE_W-1:0];
			r.mean_valid = 1'b1;
		end
		r.out_column = cb[nabd_pkg::DIM_W-1:0];
		r.out_row = rb[nabd_pkg::DIM_W-1:0];
		r.last_of_frame = last;
		expected_means.push_back(r);
	endtask

	// leave valid up; the caller drops it once the writes are done
	task automatic write_reg(logic [nabd_pkg::IDX_W-1:0] idx,
		logic [nabd_pkg::CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			nabd_pkg::CFG_IN_WIDTH:   p_in_w = value;
			nabd_pkg::CFG_IN_HEIGHT:  p_in_h = value;
			nabd_pkg::CFG_OUT_WIDTH:  p_out_w = value;
			default:                  p_out_h = value;
		endcase
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_sizes(int iw, int ih, int ow, int oh);
		drain_results();
		write_reg(nabd_pkg::CFG_IN_WIDTH, nabd_pkg::CFG_W'(iw));
		write_reg(nabd_pkg::CFG_IN_HEIGHT, nabd_pkg::CFG_W'(ih));
		write_reg(nabd_pkg::CFG_OUT_WIDTH, nabd_pkg::CFG_W'(ow));
		write_reg(nabd_pkg::CFG_OUT_HEIGHT, nabd_pkg::CFG_W'(oh));
		cfg_ch.valid <= 1'b0;
	endtask

	// valid stays up after the beat so the next sample can follow at once
	task automatic send_sample(logic [nabd_pkg::SAMPLE_W-1:0] value, logic finite,
		logic fstart);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= value;
		sample_ch.sample_finite <= finite;
		sample_ch.frame_start <= fstart;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predict_bin(value, finite, fstart);
	endtask

	function automatic logic [nabd_pkg::SAMPLE_W-1:0] rand_value();
		case ($urandom_range(5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// random samples from the start of a frame
	task automatic send_run(int n);
		for (int i = 0; i < n; i++)
			send_sample(rand_value(), $urandom_range(7) != 0, i == 0);
	endtask

	task automatic send_frame(int iw, int ih);
		send_run(iw * ih);
	endtask

	task automatic test_pass_through();
		set_sizes(3, 2, 3, 2);
		send_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
		send_sample(32'h8000_0000, 1'b1, 1'b0);
		send_sample(32'h0001_0000, 1'b0, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_sample(32'h0000_0000, 1'b1, 1'b0);
		send_sample(32'h1234_5678, 1'b1, 1'b0);
		// wrap to the next frame without a frame start
		send_sample(32'h0000_0001, 1'b1, 1'b0);
	endtask

	task automatic test_nan_bins();
		set_sizes(4, 2, 2, 1);
		send_sample(32'h0000_0003, 1'b0, 1'b1);
		send_sample(32'h0000_0005, 1'b0, 1'b0);
		send_sample(32'hFFFF_FFFD, 1'b1, 1'b0);
		send_sample(32'h0000_0000, 1'b1, 1'b0);
		send_sample(32'h0000_0007, 1'b0, 1'b0);
		send_sample(32'h0000_0009, 1'b0, 1'b0);
		send_sample(32'h8000_0000, 1'b1, 1'b0);
		send_sample(32'h8000_0000, 1'b1, 1'b0);
	endtask

	task automatic test_config_errors();
		set_sizes(2, 2, 3, 1);
		send_sample(32'h0000_0001, 1'b1, 1'b1);
		set_sizes(2, 2, 1, 3);
		send_sample(32'h0000_0001, 1'b1, 1'b0);
		set_sizes(0, 2, 1, 1);
		send_sample(32'h0000_0001, 1'b1, 1'b0);
		set_sizes(5000, 5000, 1, 1);
		send_sample(32'h0000_0001, 1'b1, 1'b0);
		set_sizes(2, 2, 1, 1);
		send_sample(32'h0000_0002, 1'b1, 1'b1);
		// restart the frame in mid-row
		send_sample(32'h0000_0004, 1'b1, 1'b1);
		send_sample(32'h0000_0006, 1'b1, 1'b0);
		send_sample(32'h0000_0008, 1'b1, 1'b0);
		send_sample(32'h0000_000A, 1'b1, 1'b0);
	endtask

	// largest sizes, first part of a frame only
	task automatic test_wide_frames();
		set_sizes(4096, 1, 4096, 1);
		send_run(40);
		set_sizes(4096, 1, 2048, 1);
		send_run(40);
		set_sizes(1, 4096, 1, 4096);
		send_run(40);
		set_sizes(1, 4096, 1, 2048);
		send_run(40);
	endtask

	task automatic test_random_frames(int n_items);
		int sent;
		int iw, ih;
		sent = 0;
		while (sent < n_items) begin
			iw = $urandom_range(1, 9);
			ih = $urandom_range(1, 7);
			set_sizes(iw, ih, $urandom_range(1, iw), $urandom_range(1, ih));
			repeat ($urandom_range(1, 3)) begin
				send_frame(iw, ih);
				sent += iw * ih;
			end
			if ($urandom_range(3) == 0) begin
				// pause until every result has come, then a noisy stray restart
				sample_ch.valid <= 1'b0;
				while (expected_means.size() != 0)
					@(posedge clk);
				send_sample(rand_value(), 1'($urandom_range(1)), 1'b1);
				sent++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		bin_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_means.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				want = expected_means.pop_front();
				if (result_ch.config_error !== want.config_error) begin
					$error("config_error exp %0b got %0b", want.config_error,
						result_ch.config_error);
					errors++;
				end
				if (!want.config_error) begin
					if (result_ch.mean_value !== want.mean_value) begin
						$error("mean_value exp %h got %h", want.mean_value, result_ch.mean_value);
						errors++;
					end
					if (result_ch.mean_valid !== want.mean_valid) begin
						$error("mean_valid exp %0b got %0b", want.mean_valid,
							result_ch.mean_valid);
						errors++;
					end
					if (result_ch.out_column !== want.out_column) begin
						$error("out_column exp %0d got %0d", want.out_column,
							result_ch.out_column);
						errors++;
					end
					if (result_ch.out_row !== want.out_row) begin
						$error("out_row exp %0d got %0d", want.out_row, result_ch.out_row);
						errors++;
					end
					if (result_ch.last_of_frame !== want.last_of_frame) begin
						$error("last_of_frame exp %0b got %0b", want.last_of_frame,
							result_ch.last_of_frame);
						errors++;
					end
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		src_idle_pct = 10;
		snk_idle_pct = 50;
		p_in_w = 1; p_in_h = 1; p_out_w = 1; p_out_h = 1;
		p_row_sum = '0;
		p_row_cnt = '0;
		p_col_pos = 0;
		p_row_pos = 0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		sample_ch.sample_finite = 1'b0;
		sample_ch.frame_start = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_through();
		test_nan_bins();
		test_config_errors();
		test_random_frames(200);
		src_idle_pct = 50;
		snk_idle_pct = 10;
		test_random_frames(200);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_frames(200);
		test_wide_frames();
		drain_results();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
